// ----- rtl/text_console_char_writer_defines.svh -----
// ============================================================================
// Text console character writer: assertion macros
// Shared assertion macros that are active in simulation and empty in synthesis.
// ============================================================================
`ifndef TEXT_CONSOLE_CHAR_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_CHAR_WRITER_DEFINES_SVH

`ifndef SYNTHESIS
`define TCCW_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("text console writer: check failed");
`define TCCW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("text console writer: check failed");
`else
`define TCCW_ASSERT(lbl, prop)
`define TCCW_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/tccw_pkg.sv -----
// ============================================================================
// Text console character writer: package
// Operation and character codes and the controller/datapath interface types.
// ============================================================================
package tccw_pkg;

  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  typedef struct packed {
    logic capture;
    logic commit_put;
    logic start_zfill;
    logic start_sfill;
    logic fill_step;
    logic read_issue;
    logic clear;
    logic load_out;
  } tccw_cmd_t;

  typedef struct packed {
    logic is_put;
    logic is_read;
    logic is_clear;
    logic need_zfill;
    logic need_scroll;
    logic fill_last;
  } tccw_status_t;

endpackage

// ----- rtl/tccw_ctrl.sv -----
// ============================================================================
// Text console character writer: controller
// Sequences each operation through execute, row fill and result hand-off.
// ============================================================================
module tccw_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  input  tccw_pkg::tccw_status_t status_i,
  output tccw_pkg::tccw_cmd_t   cmd_o
);
  import tccw_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_ZFILL = 3'd2;
  localparam logic [2:0] S_SFILL = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        if (status_i.is_put) begin
          if (status_i.need_zfill) begin
            cmd_o.start_zfill = 1'b1;
            state_d           = S_ZFILL;
          end else begin
            cmd_o.commit_put = 1'b1;
            if (status_i.need_scroll) begin
              cmd_o.start_sfill = 1'b1;
              state_d           = S_SFILL;
            end else begin
              state_d = S_DONE;
            end
          end
        end else if (status_i.is_read) begin
          cmd_o.read_issue = 1'b1;
          state_d          = S_DONE;
        end else if (status_i.is_clear) begin
          cmd_o.clear = 1'b1;
          state_d     = S_DONE;
        end else begin
          state_d = S_DONE;
        end
      end
      S_ZFILL: begin
        cmd_o.fill_step = 1'b1;
        if (status_i.fill_last) begin
          state_d = S_EXEC;
        end
      end
      S_SFILL: begin
        cmd_o.fill_step = 1'b1;
        if (status_i.fill_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- rtl/tccw_dpath.sv -----
// ============================================================================
// Text console character writer: datapath
// Cell memory as a ring of rows, row valid bits, cursor, row fill and results.
// ============================================================================
module tccw_dpath #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25,
  localparam int COL_W  = $clog2(COLUMNS),
  localparam int ROW_W  = $clog2(ROWS)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tccw_pkg::tccw_cmd_t    cmd_i,
  output tccw_pkg::tccw_status_t status_o,
  input  logic [1:0]             operation_i,
  input  logic [7:0]             char_code_i,
  input  logic [ROW_W-1:0]       read_row_i,
  input  logic [COL_W-1:0]       read_col_i,
  output logic [7:0]             cell_char_o,
  output logic [COL_W-1:0]       cursor_col_o,
  output logic [ROW_W-1:0]       cursor_row_o,
  output logic                   scrolled_o
);
  import tccw_pkg::*;

  localparam int DEPTH = ROWS * COLUMNS;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

  function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] lrow,
                                                input logic [ROW_W-1:0] base);
    logic [ROW_W:0] sum;
    sum = {1'b0, lrow} + {1'b0, base};
    if (sum >= (ROW_W+1)'(ROWS)) begin
      sum = sum - (ROW_W+1)'(ROWS);
    end
    return sum[ROW_W-1:0];
  endfunction

  function automatic logic [AW-1:0] row_addr(input logic [ROW_W-1:0] prow);
    return AW'(prow) * AW'(COLUMNS);
  endfunction

  logic [7:0]       mem [DEPTH];
  logic [7:0]       mem_rdata_q;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [7:0]       mem_wdata;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;

  logic [1:0]       op_q;
  logic [7:0]       char_q;
  logic [ROW_W-1:0] rd_row_q;
  logic [COL_W-1:0] rd_col_q;

  logic [COL_W-1:0] cur_col_q, cur_col_d;
  logic [ROW_W-1:0] cur_row_q, cur_row_d;
  logic [ROW_W-1:0] base_q;
  logic [ROWS-1:0]  row_valid_q;

  logic [AW-1:0]    fill_addr_q;
  logic [COL_W-1:0] fill_cnt_q;
  logic [7:0]       fill_data_q;
  logic [ROW_W-1:0] fill_row_q;
  logic             fill_scroll_q;

  logic             hit_q;
  logic             scroll_q;

  logic             wr_en;
  logic [ROW_W-1:0] wr_row;
  logic [COL_W-1:0] wr_col;
  logic [7:0]       wr_data;
  logic             row_up;
  logic             row_dn;
  logic             need_scroll;
  logic [ROW_W-1:0] wr_prow;
  logic [ROW_W-1:0] rd_prow;
  logic             rd_hit;

  always_comb begin
    wr_en     = 1'b0;
    wr_row    = cur_row_q;
    wr_col    = cur_col_q;
    wr_data   = char_q;
    cur_col_d = cur_col_q;
    row_up    = 1'b0;
    row_dn    = 1'b0;
    if (char_q == CH_NEWLINE) begin
      cur_col_d = '0;
      row_up    = 1'b1;
    end else if (char_q == CH_BACKSPACE) begin
      if (cur_col_q != '0) begin
        cur_col_d = cur_col_q - 1'b1;
        wr_col    = cur_col_q - 1'b1;
        wr_data   = CH_SPACE;
        wr_en     = 1'b1;
      end else if (cur_row_q != '0) begin
        row_dn    = 1'b1;
        cur_col_d = LAST_COL;
        wr_row    = cur_row_q - 1'b1;
        wr_col    = LAST_COL;
        wr_data   = CH_SPACE;
        wr_en     = 1'b1;
      end
    end else begin
      wr_en = 1'b1;
      if (char_q == CH_TAB) begin
        wr_data = CH_SPACE;
      end
      if (cur_col_q == LAST_COL) begin
        cur_col_d = '0;
        row_up    = 1'b1;
      end else begin
        cur_col_d = cur_col_q + 1'b1;
      end
    end
    need_scroll = row_up && (cur_row_q == LAST_ROW);
    if (row_dn) begin
      cur_row_d = cur_row_q - 1'b1;
    end else if (row_up && !need_scroll) begin
      cur_row_d = cur_row_q + 1'b1;
    end else begin
      cur_row_d = cur_row_q;
    end
  end

  assign wr_prow = phys_row(wr_row, base_q);
  assign rd_prow = phys_row(rd_row_q, base_q);
  assign rd_hit  = (rd_row_q < ROWS) && (rd_col_q < COLUMNS) && row_valid_q[rd_prow];

  assign status_o.is_put      = (op_q == OP_PUT);
  assign status_o.is_read     = (op_q == OP_READ);
  assign status_o.is_clear    = (op_q == OP_CLEAR);
  assign status_o.need_zfill  = wr_en && !row_valid_q[wr_prow];
  assign status_o.need_scroll = need_scroll;
  assign status_o.fill_last   = (fill_cnt_q == LAST_COL);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = row_addr(wr_prow) + AW'(wr_col);
    mem_wdata = wr_data;
    if (cmd_i.fill_step) begin
      mem_we    = 1'b1;
      mem_waddr = fill_addr_q;
      mem_wdata = fill_data_q;
    end else if (cmd_i.commit_put && wr_en) begin
      mem_we = 1'b1;
    end
  end

  assign mem_re    = cmd_i.read_issue && rd_hit;
  assign mem_raddr = row_addr(rd_prow) + AW'(rd_col_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      base_q      <= '0;
      row_valid_q <= '0;
      hit_q       <= 1'b0;
      scroll_q    <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        hit_q    <= 1'b0;
        scroll_q <= 1'b0;
      end
      if (cmd_i.read_issue) begin
        hit_q <= rd_hit;
      end
      if (cmd_i.commit_put) begin
        cur_col_q <= cur_col_d;
        cur_row_q <= cur_row_d;
        scroll_q  <= need_scroll;
      end
      if (cmd_i.fill_step && status_o.fill_last) begin
        row_valid_q[fill_row_q] <= 1'b1;
        if (fill_scroll_q) begin
          base_q <= (base_q == LAST_ROW) ? '0 : base_q + 1'b1;
        end
      end
      if (cmd_i.clear) begin
        cur_col_q   <= '0;
        cur_row_q   <= '0;
        base_q      <= '0;
        row_valid_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q     <= operation_i;
      char_q   <= char_code_i;
      rd_row_q <= read_row_i;
      rd_col_q <= read_col_i;
    end
    if (cmd_i.start_zfill) begin
      fill_addr_q   <= row_addr(wr_prow);
      fill_row_q    <= wr_prow;
      fill_data_q   <= 8'h00;
      fill_scroll_q <= 1'b0;
      fill_cnt_q    <= '0;
    end else if (cmd_i.start_sfill) begin
      fill_addr_q   <= row_addr(base_q);
      fill_row_q    <= base_q;
      fill_data_q   <= CH_SPACE;
      fill_scroll_q <= 1'b1;
      fill_cnt_q    <= '0;
    end else if (cmd_i.fill_step) begin
      fill_addr_q <= fill_addr_q + 1'b1;
      fill_cnt_q  <= fill_cnt_q + 1'b1;
    end
    if (cmd_i.load_out) begin
      cell_char_o  <= ((op_q == OP_READ) && hit_q) ? mem_rdata_q : 8'h00;
      cursor_col_o <= cur_col_q;
      cursor_row_o <= cur_row_q;
      scrolled_o   <= (op_q == OP_PUT) && scroll_q;
    end
  end

endmodule

// ----- rtl/text_console_char_writer.sv -----
// ============================================================================
// Text console character writer
// Character cell store with cursor, line wrap, scroll, clear and cell read.
// ============================================================================
// Each transfer on the input side is one operation and yields exactly one
// result transfer. A read, a clear, an unused code or a put into a row that
// already holds data passes from acceptance through the execute and done
// states to the result register. A put that writes into a row untouched since
// reset or the last clear first zero-fills that row. A put that scrolls
// blanks the new bottom row with spaces, as rows are kept as a ring in a cell
// memory with one write port and one cell is written per cycle. Reset and
// clear take effect at once through per-row valid bits, so there is no
// clearing pass. The next operation is accepted while a finished result is
// still waiting in the output register.
module text_console_char_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25,
  localparam int COL_W  = $clog2(COLUMNS),
  localparam int ROW_W  = $clog2(ROWS)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       operation_i,
  input  logic [7:0]       char_code_i,
  input  logic [ROW_W-1:0] read_row_i,
  input  logic [COL_W-1:0] read_col_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       cell_char_o,
  output logic [COL_W-1:0] cursor_col_o,
  output logic [ROW_W-1:0] cursor_row_o,
  output logic             scrolled_o
);
  import tccw_pkg::*;

  `include "text_console_char_writer_defines.svh"

  tccw_cmd_t    cmd;
  tccw_status_t status;

  tccw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tccw_dpath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .operation_i  (operation_i),
    .char_code_i  (char_code_i),
    .read_row_i   (read_row_i),
    .read_col_i   (read_col_i),
    .cell_char_o  (cell_char_o),
    .cursor_col_o (cursor_col_o),
    .cursor_row_o (cursor_row_o),
    .scrolled_o   (scrolled_o)
  );

  `TCCW_ASSERT(a_cursor_in_range, !out_valid_o || ((cursor_row_o < ROWS) && (cursor_col_o < COLUMNS)))
  `TCCW_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  `TCCW_ASSERT(a_scroll_on_bottom, !(out_valid_o && scrolled_o) || (cursor_row_o == ROWS - 1))
  `TCCW_ASSERT(a_single_writer, !(cmd.fill_step && cmd.commit_put))

endmodule
